// File: sv/vesl_pkg.sv
// ----------------------------------------------------------------------------
// vesl_pkg
// Shared widths, constants, command type and helper functions of the velocity
// estimator and slew limiter.
// ----------------------------------------------------------------------------
package vesl_pkg;

	localparam int POS_W_DEF = 32;
	localparam int CH_N      = 5;
	localparam int PWR_N     = 3;
	localparam int DT_W      = 16;
	localparam int SPEED_W   = 32;
	localparam int POWER_W   = 16;
	localparam int RATE_W    = 24;
	localparam int PROD_W    = RATE_W + DT_W;
	localparam int MS_W      = 10;
	localparam int SPD_Q_W   = SPEED_W + 1;
	localparam int STEP_W    = 16;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = RATE_W;

	localparam logic [CFG_IDX_W-1:0] CFG_DRIVE_EN   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_DRIVE_RATE = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_TILT_EN    = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_TILT_RATE  = 2'd3;

	localparam logic [DT_W-1:0]           DT_ONE      = 16'd1;
	localparam logic signed [POWER_W-1:0] POWER_LIMIT = 16'sd25600;
	localparam logic [SPEED_W-1:0]        SPEED_MAX   = 32'h7FFF_FFFF;
	localparam logic [SPEED_W-1:0]        SPEED_MIN   = 32'h8000_0000;

	// The slew step is the rate product over 1000, taken as a multiply by a
	// scaled reciprocal. Products at or above STEP_SAT give a step beyond any
	// possible power error, so the step saturates there.
	localparam int STEP_IN_W = 26;
	localparam int RECIP_W   = 27;
	localparam int RECIP_SH  = 36;
	localparam logic [RECIP_W-1:0] STEP_RECIP = 27'd68719477;
	localparam logic [PROD_W-1:0]  STEP_SAT   = 40'd65536000;

	typedef struct packed {
		logic cap;
		logic diff;
		logic scale;
		logic load;
		logic step;
		logic fin;
	} vesl_cmd_t;

	// Number of divider iterations: one per bit of the scaled position change.
	function automatic int iter_count(input int pos_w);
		return pos_w + MS_W;
	endfunction

endpackage

// File: sv/velocity_estimator_slew_limiter.sv
// ----------------------------------------------------------------------------
// velocity_estimator_slew_limiter
// Each accepted request is one timing tick. The block reports five encoder
// speeds (position change times 1000 over the elapsed milliseconds, truncated
// toward zero and saturated to 32 bits, zero elapsed time counted as one) and
// moves the right, left and tilter powers toward their targets by at most
// rate * elapsed / 1000 when slewing is enabled. The speeds come from the
// bit-serial speed dividers, one quotient bit per cycle, which all five
// lanes run side by side. A finished result waits in the output register
// while the next request is taken. Configuration writes are always ready and
// should only be issued while no request is in flight.
// ----------------------------------------------------------------------------
module velocity_estimator_slew_limiter #(
	parameter int POSITION_WIDTH = vesl_pkg::POS_W_DEF
) (
	input  logic                                   clk,
	input  logic                                   arst_n,

	input  logic                                   cfg_valid,
	output logic                                   cfg_ready,
	input  logic [vesl_pkg::CFG_IDX_W-1:0]         cfg_index,
	input  logic [vesl_pkg::CFG_DATA_W-1:0]        cfg_data,

	input  logic                                   in_valid,
	output logic                                   in_stall,
	input  logic [vesl_pkg::DT_W-1:0]              elapsed_ms,
	input  logic signed [POSITION_WIDTH-1:0]       right_position,
	input  logic signed [POSITION_WIDTH-1:0]       left_position,
	input  logic signed [POSITION_WIDTH-1:0]       tilter_position,
	input  logic signed [POSITION_WIDTH-1:0]       arm_position,
	input  logic signed [POSITION_WIDTH-1:0]       intake_position,
	input  logic signed [vesl_pkg::POWER_W-1:0]    right_target,
	input  logic signed [vesl_pkg::POWER_W-1:0]    left_target,
	input  logic signed [vesl_pkg::POWER_W-1:0]    tilter_target,

	output logic                                   out_valid,
	input  logic                                   out_stall,
	output logic signed [vesl_pkg::SPEED_W-1:0]    right_speed,
	output logic signed [vesl_pkg::SPEED_W-1:0]    left_speed,
	output logic signed [vesl_pkg::SPEED_W-1:0]    tilter_speed,
	output logic signed [vesl_pkg::SPEED_W-1:0]    arm_speed,
	output logic signed [vesl_pkg::SPEED_W-1:0]    intake_speed,
	output logic signed [vesl_pkg::POWER_W-1:0]    right_power,
	output logic signed [vesl_pkg::POWER_W-1:0]    left_power,
	output logic signed [vesl_pkg::POWER_W-1:0]    tilter_power
);

	localparam int ITERS = vesl_pkg::iter_count(POSITION_WIDTH);

	vesl_pkg::vesl_cmd_t                   cmd;
	logic signed [POSITION_WIDTH-1:0]      pos_in [vesl_pkg::CH_N];
	logic signed [vesl_pkg::POWER_W-1:0]   tgt_in [vesl_pkg::PWR_N];
	logic signed [vesl_pkg::SPEED_W-1:0]   speed_out [vesl_pkg::CH_N];
	logic signed [vesl_pkg::POWER_W-1:0]   power_out [vesl_pkg::PWR_N];

	assign cfg_ready = 1'b1;

	assign pos_in[0] = right_position;
	assign pos_in[1] = left_position;
	assign pos_in[2] = tilter_position;
	assign pos_in[3] = arm_position;
	assign pos_in[4] = intake_position;
	assign tgt_in[0] = right_target;
	assign tgt_in[1] = left_target;
	assign tgt_in[2] = tilter_target;

	vesl_ctrl #(
		.ITERS(ITERS)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.cmd      (cmd)
	);

	vesl_dp #(
		.POSITION_WIDTH(POSITION_WIDTH)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.cfg_we    (cfg_valid && cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.elapsed_ms(elapsed_ms),
		.pos_in    (pos_in),
		.tgt_in    (tgt_in),
		.speed_out (speed_out),
		.power_out (power_out)
	);

	assign right_speed  = speed_out[0];
	assign left_speed   = speed_out[1];
	assign tilter_speed = speed_out[2];
	assign arm_speed    = speed_out[3];
	assign intake_speed = speed_out[4];
	assign right_power  = power_out[0];
	assign left_power   = power_out[1];
	assign tilter_power = power_out[2];

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> in_stall)
		else $error("A request was accepted but the block did not go busy.");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.fin |-> !(out_valid && out_stall))
		else $error("A result was written over one that was still held.");

	a_step_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.step || cmd.load) |-> in_stall)
		else $error("The dividers ran while the input side was open.");

endmodule

// File: sv/vesl_div.sv
// ----------------------------------------------------------------------------
// vesl_div
// Restoring divider lane, one quotient bit per step, with a sticky flag for
// quotient bits that fall off the top of the quotient register.
// ----------------------------------------------------------------------------
module vesl_div #(
	parameter int NUM_W = 42,
	parameter int DEN_W = 16,
	parameter int Q_W   = 33
) (
	input  logic             clk,
	input  logic             load,
	input  logic             step,
	input  logic [NUM_W-1:0] num,
	input  logic [DEN_W-1:0] den,
	output logic [Q_W-1:0]   quo,
	output logic             ovf
);

	logic [NUM_W-1:0] num_q;
	logic [DEN_W-1:0] den_q;
	logic [DEN_W-1:0] rem_q;
	logic [Q_W-1:0]   quo_q;
	logic             ovf_q;
	logic [DEN_W:0]   trial;
	logic [DEN_W:0]   diff;
	logic             ge;

	always_comb begin
		trial = {rem_q, num_q[NUM_W-1]};
		ge    = (trial >= {1'b0, den_q});
		diff  = trial - {1'b0, den_q};
	end

	always_ff @(posedge clk) begin
		if (load) begin
			num_q <= num;
			den_q <= den;
			rem_q <= '0;
			quo_q <= '0;
			ovf_q <= 1'b0;
		end else if (step) begin
			num_q <= {num_q[NUM_W-2:0], 1'b0};
			rem_q <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
			quo_q <= {quo_q[Q_W-2:0], ge};
			ovf_q <= ovf_q | quo_q[Q_W-1];
		end
	end

	assign quo = quo_q;
	assign ovf = ovf_q;

endmodule

// File: sv/vesl_ctrl.sv
// ----------------------------------------------------------------------------
// vesl_ctrl
// Sequencer of one tick: capture, difference, scale, divider load, divider
// iterations and result write into the output register.
// ----------------------------------------------------------------------------
module vesl_ctrl #(
	parameter int ITERS = 42
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	output logic                 out_valid,
	input  logic                 out_stall,
	output vesl_pkg::vesl_cmd_t  cmd
);

	localparam int CNT_W = $clog2(ITERS);

	typedef enum logic [5:0] {
		S_IDLE  = 6'b000001,
		S_DIFF  = 6'b000010,
		S_SCALE = 6'b000100,
		S_LOAD  = 6'b001000,
		S_DIV   = 6'b010000,
		S_FIN   = 6'b100000
	} state_t;

	state_t             state_q;
	state_t             state_d;
	logic [CNT_W-1:0]   cnt_q;
	logic               out_valid_q;

	always_comb begin
		cmd      = '0;
		state_d  = state_q;
		in_stall = (state_q != S_IDLE);
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.cap = 1'b1;
					state_d = S_DIFF;
				end
			end
			S_DIFF: begin
				cmd.diff = 1'b1;
				state_d  = S_SCALE;
			end
			S_SCALE: begin
				cmd.scale = 1'b1;
				state_d   = S_LOAD;
			end
			S_LOAD: begin
				cmd.load = 1'b1;
				state_d  = S_DIV;
			end
			S_DIV: begin
				cmd.step = 1'b1;
				if (cnt_q == '0) begin
					state_d = S_FIN;
				end
			end
			S_FIN: begin
				if (!out_valid_q || !out_stall) begin
					cmd.fin = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load) begin
				cnt_q <= CNT_W'(ITERS - 1);
			end else if (cmd.step && (cnt_q != '0)) begin
				cnt_q <= cnt_q - 1'b1;
			end
			if (cmd.fin) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

endmodule

// File: sv/vesl_dp.sv
// ----------------------------------------------------------------------------
// vesl_dp
// Datapath: configuration registers, previous positions, held powers, the
// position differences, five speed divider lanes, two slew step multipliers
// and the result registers.
// ----------------------------------------------------------------------------
module vesl_dp #(
	parameter int POSITION_WIDTH = vesl_pkg::POS_W_DEF
) (
	input  logic                                     clk,
	input  logic                                     arst_n,
	input  vesl_pkg::vesl_cmd_t                      cmd,
	input  logic                                     cfg_we,
	input  logic [vesl_pkg::CFG_IDX_W-1:0]           cfg_index,
	input  logic [vesl_pkg::CFG_DATA_W-1:0]          cfg_data,
	input  logic [vesl_pkg::DT_W-1:0]                elapsed_ms,
	input  logic signed [POSITION_WIDTH-1:0]         pos_in [vesl_pkg::CH_N],
	input  logic signed [vesl_pkg::POWER_W-1:0]      tgt_in [vesl_pkg::PWR_N],
	output logic signed [vesl_pkg::SPEED_W-1:0]      speed_out [vesl_pkg::CH_N],
	output logic signed [vesl_pkg::POWER_W-1:0]      power_out [vesl_pkg::PWR_N]
);

	localparam int P     = POSITION_WIDTH;
	localparam int NUM_W = P + vesl_pkg::MS_W;
	localparam int ITERS = vesl_pkg::iter_count(POSITION_WIDTH);

	logic                                  drive_en_q;
	logic [vesl_pkg::RATE_W-1:0]           drive_rate_q;
	logic                                  tilt_en_q;
	logic [vesl_pkg::RATE_W-1:0]           tilt_rate_q;

	logic [vesl_pkg::DT_W-1:0]             dt_q;
	logic signed [P-1:0]                   now_q [vesl_pkg::CH_N];
	logic signed [P-1:0]                   prev_q [vesl_pkg::CH_N];
	logic signed [vesl_pkg::POWER_W-1:0]   tgt_q [vesl_pkg::PWR_N];
	logic signed [vesl_pkg::POWER_W-1:0]   power_q [vesl_pkg::PWR_N];
	logic [P-1:0]                          mag_q [vesl_pkg::CH_N];
	logic                                  neg_q [vesl_pkg::CH_N];
	logic [NUM_W-1:0]                      n_q [vesl_pkg::CH_N];
	logic [vesl_pkg::PROD_W-1:0]           prod_q [2];
	logic [vesl_pkg::STEP_W-1:0]           step_q [2];
	logic [vesl_pkg::SPEED_W-1:0]          speed_q [vesl_pkg::CH_N];

	logic signed [P:0]                     diff [vesl_pkg::CH_N];
	logic [P:0]                            diff_abs [vesl_pkg::CH_N];
	logic [ITERS-1:0]                      spd_num [vesl_pkg::CH_N];
	logic [vesl_pkg::SPD_Q_W-1:0]          spd_quo [vesl_pkg::CH_N];
	logic                                  spd_ovf [vesl_pkg::CH_N];
	logic [vesl_pkg::PROD_W-1:0]           prod [2];

	function automatic logic signed [vesl_pkg::POWER_W-1:0] sat_target(
		input logic signed [vesl_pkg::POWER_W-1:0] t
	);
		logic signed [vesl_pkg::POWER_W-1:0] r;
		if (t > vesl_pkg::POWER_LIMIT) begin
			r = vesl_pkg::POWER_LIMIT;
		end else if (t < -vesl_pkg::POWER_LIMIT) begin
			r = -vesl_pkg::POWER_LIMIT;
		end else begin
			r = t;
		end
		return r;
	endfunction

	function automatic logic [vesl_pkg::STEP_W-1:0] slew_step(
		input logic [vesl_pkg::PROD_W-1:0] pr
	);
		logic [vesl_pkg::STEP_IN_W+vesl_pkg::RECIP_W-1:0] m;
		logic [vesl_pkg::STEP_W-1:0]                     r;
		m = {{vesl_pkg::RECIP_W{1'b0}}, pr[vesl_pkg::STEP_IN_W-1:0]} *
			{{vesl_pkg::STEP_IN_W{1'b0}}, vesl_pkg::STEP_RECIP};
		if (pr >= vesl_pkg::STEP_SAT) begin
			r = '1;
		end else begin
			r = m[vesl_pkg::RECIP_SH +: vesl_pkg::STEP_W];
		end
		return r;
	endfunction

	function automatic logic signed [vesl_pkg::POWER_W-1:0] slew_next(
		input logic signed [vesl_pkg::POWER_W-1:0] p,
		input logic signed [vesl_pkg::POWER_W-1:0] t,
		input logic                                en,
		input logic [vesl_pkg::STEP_W-1:0]         s
	);
		logic signed [vesl_pkg::POWER_W:0]   err;
		logic signed [vesl_pkg::POWER_W:0]   lim;
		logic signed [vesl_pkg::POWER_W-1:0] r;
		err = (vesl_pkg::POWER_W+1)'(t) - (vesl_pkg::POWER_W+1)'(p);
		lim = $signed({1'b0, s});
		if (!en) begin
			r = t;
		end else if (err > lim) begin
			r = vesl_pkg::POWER_W'((vesl_pkg::POWER_W+1)'(p) + lim);
		end else if (err < -lim) begin
			r = vesl_pkg::POWER_W'((vesl_pkg::POWER_W+1)'(p) - lim);
		end else begin
			r = t;
		end
		return r;
	endfunction

	function automatic logic [vesl_pkg::SPEED_W-1:0] speed_sat(
		input logic [vesl_pkg::SPD_Q_W-1:0] q,
		input logic                         ovf,
		input logic                         neg
	);
		logic [vesl_pkg::SPEED_W-1:0] r;
		if (neg) begin
			if (ovf || q[vesl_pkg::SPEED_W] ||
					(q[vesl_pkg::SPEED_W-1] && (q[vesl_pkg::SPEED_W-2:0] != '0))) begin
				r = vesl_pkg::SPEED_MIN;
			end else begin
				r = '0 - q[vesl_pkg::SPEED_W-1:0];
			end
		end else begin
			if (ovf || q[vesl_pkg::SPEED_W] || q[vesl_pkg::SPEED_W-1]) begin
				r = vesl_pkg::SPEED_MAX;
			end else begin
				r = q[vesl_pkg::SPEED_W-1:0];
			end
		end
		return r;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			drive_en_q   <= 1'b0;
			drive_rate_q <= '0;
			tilt_en_q    <= 1'b0;
			tilt_rate_q  <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				vesl_pkg::CFG_DRIVE_EN:   drive_en_q   <= cfg_data[0];
				vesl_pkg::CFG_DRIVE_RATE: drive_rate_q <= cfg_data;
				vesl_pkg::CFG_TILT_EN:    tilt_en_q    <= cfg_data[0];
				vesl_pkg::CFG_TILT_RATE:  tilt_rate_q  <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		for (int c = 0; c < vesl_pkg::CH_N; c++) begin
			diff[c]     = (P+1)'(now_q[c]) - (P+1)'(prev_q[c]);
			diff_abs[c] = diff[c][P] ? ((P+1)'(0) - diff[c]) : diff[c];
			spd_num[c]  = ITERS'(n_q[c] - NUM_W'({mag_q[c], 3'b000}));
		end
		prod[0] = drive_rate_q * dt_q;
		prod[1] = tilt_rate_q * dt_q;
	end

	always_ff @(posedge clk) begin
		if (cmd.cap) begin
			dt_q <= (elapsed_ms == '0) ? vesl_pkg::DT_ONE : elapsed_ms;
			for (int c = 0; c < vesl_pkg::CH_N; c++) begin
				now_q[c] <= pos_in[c];
			end
			for (int k = 0; k < vesl_pkg::PWR_N; k++) begin
				tgt_q[k] <= sat_target(tgt_in[k]);
			end
		end
		if (cmd.diff) begin
			for (int c = 0; c < vesl_pkg::CH_N; c++) begin
				mag_q[c] <= diff_abs[c][P-1:0];
				neg_q[c] <= diff[c][P];
			end
			prod_q[0] <= prod[0];
			prod_q[1] <= prod[1];
		end
		if (cmd.scale) begin
			for (int c = 0; c < vesl_pkg::CH_N; c++) begin
				n_q[c] <= {mag_q[c], 10'b0} - NUM_W'({mag_q[c], 4'b0000});
			end
			step_q[0] <= slew_step(prod_q[0]);
			step_q[1] <= slew_step(prod_q[1]);
		end
		if (cmd.fin) begin
			for (int c = 0; c < vesl_pkg::CH_N; c++) begin
				speed_q[c] <= speed_sat(spd_quo[c], spd_ovf[c], neg_q[c]);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int c = 0; c < vesl_pkg::CH_N; c++) begin
				prev_q[c] <= '0;
			end
			for (int k = 0; k < vesl_pkg::PWR_N; k++) begin
				power_q[k] <= '0;
			end
		end else begin
			if (cmd.diff) begin
				for (int c = 0; c < vesl_pkg::CH_N; c++) begin
					prev_q[c] <= now_q[c];
				end
			end
			if (cmd.fin) begin
				power_q[0] <= slew_next(power_q[0], tgt_q[0], drive_en_q, step_q[0]);
				power_q[1] <= slew_next(power_q[1], tgt_q[1], drive_en_q, step_q[0]);
				power_q[2] <= slew_next(power_q[2], tgt_q[2], tilt_en_q, step_q[1]);
			end
		end
	end

	for (genvar c = 0; c < vesl_pkg::CH_N; c++) begin : g_spd
		vesl_div #(
			.NUM_W(ITERS),
			.DEN_W(vesl_pkg::DT_W),
			.Q_W  (vesl_pkg::SPD_Q_W)
		) u_div (
			.clk (clk),
			.load(cmd.load),
			.step(cmd.step),
			.num (spd_num[c]),
			.den (dt_q),
			.quo (spd_quo[c]),
			.ovf (spd_ovf[c])
		);
		assign speed_out[c] = speed_q[c];
	end

	assign power_out = power_q;

endmodule
